### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property, disabled while reset is high.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### rtl/ptra_pkg.sv
package ptra_pkg;

   localparam int unsigned ROWS_PER_TILE = 8;
   localparam logic [5:0]  MAX_WIDTH_TILES  = 6'd32;
   localparam logic [5:0]  MAX_HEIGHT_TILES = 6'd32;
   localparam logic [2:0]  LAST_ROW_IN_TILE = 3'(ROWS_PER_TILE - 1);

   // register indexes on the csr port
   localparam logic [1:0] CSR_WIDTH_TILES  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT_TILES = 2'd1;
   localparam logic [1:0] CSR_TRANSPOSED   = 2'd2;

   // clamped image geometry
   typedef struct packed {
      logic [5:0] width_tiles;
      logic [5:0] height_tiles;
      logic       transposed;
   } geom_type;

   // position of one tile row in the image
   typedef struct packed {
      logic [2:0] row_in_tile;
      logic [4:0] fast_tile_count;
      logic [4:0] slow_tile_count;
      logic       last_row;
   } tile_pos_type;

   // contents of the input register
   typedef struct packed {
      logic [7:0]   low_plane;
      logic [7:0]   high_plane;
      tile_pos_type pos;
   } row_item_type;

   // zero acts as one, oversize acts as the maximum
   function automatic logic [5:0] clamp_size(input logic [5:0] v, input logic [5:0] maxv);
      logic [5:0] r;
      if (v == 6'd0) begin
         r = 6'd1;
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/ptra_tile_counter.sv
`include "assert_macros.svh"

module ptra_tile_counter
   import ptra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  geom_type     geom,
   input  logic         step,
   output tile_pos_type pos
);

   logic [2:0] row_ff, row_in;
   logic [4:0] fast_ff, fast_in;
   logic [4:0] slow_ff, slow_in;
   logic [5:0] fast_lim, slow_lim;
   logic       fast_end, slow_end;

   assign fast_lim = geom.transposed ? geom.height_tiles : geom.width_tiles;
   assign slow_lim = geom.transposed ? geom.width_tiles  : geom.height_tiles;

   // a counter at or past its last value (limit - 1) wraps on its next step
   assign fast_end = ({1'b0, fast_ff} + 6'd1) >= fast_lim;
   assign slow_end = ({1'b0, slow_ff} + 6'd1) >= slow_lim;

   assign pos.row_in_tile     = row_ff;
   assign pos.fast_tile_count = fast_ff;
   assign pos.slow_tile_count = slow_ff;
   assign pos.last_row        = (row_ff == LAST_ROW_IN_TILE) && fast_end && slow_end;

   always_comb begin
      row_in  = row_ff;
      fast_in = fast_ff;
      slow_in = slow_ff;
      if (step) begin
         if (row_ff == LAST_ROW_IN_TILE) begin
            row_in = 3'd0;
            if (fast_end) begin
               fast_in = 5'd0;
               slow_in = slow_end ? 5'd0 : slow_ff + 5'd1;
            end else begin
               fast_in = fast_ff + 5'd1;
            end
         end else begin
            row_in = row_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= 3'd0;
         fast_ff <= 5'd0;
         slow_ff <= 5'd0;
      end else begin
         row_ff  <= row_in;
         fast_ff <= fast_in;
         slow_ff <= slow_in;
      end
   end

   `ASSERT_PROP(a_last_wraps_all, clock, reset, step && pos.last_row |=> (row_ff == 3'd0) && (fast_ff == 5'd0) && (slow_ff == 5'd0), "counters did not wrap after last row")
   `ASSERT_PROP(a_hold_when_idle, clock, reset, !step |=> $stable({row_ff, fast_ff, slow_ff}), "counters moved without a transfer")

endmodule

### rtl/ptra_row_pack.sv
`include "assert_macros.svh"

module ptra_row_pack
   import ptra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  geom_type     geom,
   input  logic         item_valid,
   input  row_item_type item,
   output logic         item_take,
   input  logic         out_ready,
   output logic         out_valid,
   output logic [15:0]  pixel_row,
   output logic [12:0]  dest_index,
   output logic         last_row
);

   logic        valid_ff, valid_in;
   logic [15:0] pixel_ff, pixel_in;
   logic [12:0] index_ff, index_in;
   logic        last_ff;
   logic [7:0]  line;
   logic [4:0]  column;
   logic [13:0] product;
   logic [13:0] sum;

   assign item_take = item_valid && (!valid_ff || out_ready);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         pixel_in[2*i]     = item.low_plane[i];
         pixel_in[2*i + 1] = item.high_plane[i];
      end
   end

   // index = (tile row * 8 + row) * width + tile column
   always_comb begin
      if (geom.transposed) begin
         line   = {item.pos.fast_tile_count, item.pos.row_in_tile};
         column = item.pos.slow_tile_count;
      end else begin
         line   = {item.pos.slow_tile_count, item.pos.row_in_tile};
         column = item.pos.fast_tile_count;
      end
      product  = {6'd0, line} * {8'd0, geom.width_tiles};
      sum      = product + {9'd0, column};
      index_in = sum[12:0];
   end

   assign valid_in = item_take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         pixel_ff <= pixel_in;
         index_ff <= index_in;
         last_ff  <= item.pos.last_row;
      end
   end

   assign out_valid  = valid_ff;
   assign pixel_row  = pixel_ff;
   assign dest_index = index_ff;
   assign last_row   = last_ff;

   `ASSERT_PROP(a_no_overwrite, clock, reset, valid_ff && !out_ready |-> !item_take, "result register overwritten before transfer")

endmodule

### rtl/planar_tile_row_arranger.sv
// Planar tile row arranger. Each req transfer carries one row of an 8x8 tile
// of 2-bit-per-pixel planar data (low plane byte, high plane byte), tiles in
// source order, eight rows per tile. Each rsp transfer returns the row as one
// 16-bit word (pixel i in bits 2i+1:2i, high plane in the upper bit) with its
// word index in a raster image width_tiles tiles wide; tiles go row-major, or
// column-major when transposed is set. tlast marks row 7 of the final tile,
// after which the position counters wrap to the start of the image. Size
// registers of zero act as one and sizes above 32 act as 32; the index wraps
// modulo 8192. Throughput is one row per clock while rsp_tready stays high. A
// req transfer reaches rsp_tvalid through the input register and then the
// result register, where the interleave and the 8x6-bit index multiply
// sit. Write the csr registers only while no row is in flight.
`include "assert_macros.svh"

module planar_tile_row_arranger
   import ptra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata,
   // tile rows in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] low_plane, [15:8] high_plane
   // arranged rows out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] pixel_row, [28:16] dest_index, [31:29] zero
   output logic        rsp_tlast    // last_row
);

   logic [5:0]   width_ff, height_ff;
   logic         transposed_ff;
   geom_type     geom;

   logic         req_xfer;
   tile_pos_type pos;

   logic         s1_valid_ff, s1_valid_in;
   row_item_type s1_ff;
   logic         s1_take;

   logic [15:0]  pixel_row;
   logic [12:0]  dest_index;
   logic         last_row;

   // csr registers, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 6'd1;
         height_ff     <= 6'd1;
         transposed_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_TILES:  width_ff      <= csr_wdata;
            CSR_HEIGHT_TILES: height_ff     <= csr_wdata;
            CSR_TRANSPOSED:   transposed_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign geom.width_tiles  = clamp_size(width_ff, MAX_WIDTH_TILES);
   assign geom.height_tiles = clamp_size(height_ff, MAX_HEIGHT_TILES);
   assign geom.transposed   = transposed_ff;

   // input register takes a new row whenever it is empty or draining
   assign req_tready = !s1_valid_ff || s1_take;
   assign req_xfer   = req_tvalid && req_tready;

   // position of the row being accepted; steps on each transfer
   ptra_tile_counter u_counter (
      .clock (clock),
      .reset (reset),
      .geom  (geom),
      .step  (req_xfer),
      .pos   (pos)
   );

   assign s1_valid_in = req_xfer ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff.low_plane  <= req_tdata[7:0];
         s1_ff.high_plane <= req_tdata[15:8];
         s1_ff.pos        <= pos;
      end
   end

   // interleave, index and result register
   ptra_row_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .item_valid (s1_valid_ff),
      .item       (s1_ff),
      .item_take  (s1_take),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .pixel_row  (pixel_row),
      .dest_index (dest_index),
      .last_row   (last_row)
   );

   assign rsp_tdata = {3'd0, dest_index, pixel_row};
   assign rsp_tlast = last_row;

   `ASSERT_PROP(a_s1_holds, clock, reset, s1_valid_ff && !s1_take |=> s1_valid_ff && $stable(s1_ff), "input register lost a stalled row")
   `ASSERT_PROP(a_full_accept_drains, clock, reset, req_xfer && s1_valid_ff |-> s1_take, "row accepted into a full input register")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

// Mirror of the arranger: geometry registers, position counters and the
// queue of arranged rows still owed by the block.
class tile_row_scoreboard;

   typedef struct {
      logic [15:0] pixel_row;
      logic [12:0] dest_index;
      logic        last_row;
   } arranged_row_type;

   logic [5:0]       width_reg;
   logic [5:0]       height_reg;
   logic             transposed_reg;
   logic [2:0]       row_in_tile;
   logic [4:0]       fast_tile;
   logic [4:0]       slow_tile;
   arranged_row_type owed_rows[$];
   int               errors;

   function new();
      width_reg      = 6'd1;
      height_reg     = 6'd1;
      transposed_reg = 1'b0;
      row_in_tile    = '0;
      fast_tile      = '0;
      slow_tile      = '0;
      errors         = 0;
   endfunction

   // zero acts as one, anything above the maximum acts as the maximum
   function logic [5:0] effective_size(logic [5:0] v, logic [5:0] maxv);
      return (v == 6'd0) ? 6'd1 : ((v > maxv) ? maxv : v);
   endfunction

   function void write_csr(logic [1:0] index, logic [5:0] value);
      case (index)
         ptra_pkg::CSR_WIDTH_TILES:  width_reg      = value;
         ptra_pkg::CSR_HEIGHT_TILES: height_reg     = value;
         ptra_pkg::CSR_TRANSPOSED:   transposed_reg = value[0];
         default: ;
      endcase
   endfunction

   // work out the arranged row for one accepted tile row, then step counters
   function void note_row(logic [7:0] low_plane, logic [7:0] high_plane);
      arranged_row_type r;
      logic [5:0]       w;
      logic [5:0]       h;
      logic [5:0]       fast_lim;
      logic [5:0]       slow_lim;
      logic             fast_end;
      logic             slow_end;
      int unsigned      idx;
      w        = effective_size(width_reg, ptra_pkg::MAX_WIDTH_TILES);
      h        = effective_size(height_reg, ptra_pkg::MAX_HEIGHT_TILES);
      fast_lim = transposed_reg ? h : w;
      slow_lim = transposed_reg ? w : h;
      fast_end = ({1'b0, fast_tile} + 6'd1) >= fast_lim;
      slow_end = ({1'b0, slow_tile} + 6'd1) >= slow_lim;
      for (int i = 0; i < 8; i++) begin
         r.pixel_row[2*i]   = low_plane[i];
         r.pixel_row[2*i+1] = high_plane[i];
      end
      if (transposed_reg) begin
         idx = row_in_tile * w + fast_tile * ptra_pkg::ROWS_PER_TILE * w + slow_tile;
      end else begin
         idx = row_in_tile * w + fast_tile + slow_tile * ptra_pkg::ROWS_PER_TILE * w;
      end
      r.dest_index = idx[12:0];
      r.last_row   = (row_in_tile == ptra_pkg::LAST_ROW_IN_TILE) && fast_end && slow_end;
      owed_rows.push_back(r);

      if (row_in_tile == ptra_pkg::LAST_ROW_IN_TILE) begin
         row_in_tile = '0;
         if (fast_end) begin
            fast_tile = '0;
            slow_tile = slow_end ? 5'd0 : slow_tile + 5'd1;
         end else begin
            fast_tile = fast_tile + 5'd1;
         end
      end else begin
         row_in_tile = row_in_tile + 3'd1;
      end
   endfunction

   function void check_row(logic [15:0] pixel_row, logic [12:0] dest_index, logic last_row);
      arranged_row_type r;
      if (owed_rows.size() == 0) begin
         $display("%0t: unexpected rsp transfer: pixel_row %h dest_index %0d last_row %b",
                  $time, pixel_row, dest_index, last_row);
         errors++;
         return;
      end
      r = owed_rows.pop_front();
      if (pixel_row !== r.pixel_row) begin
         $display("%0t: pixel_row mismatch: expected %h, actual %h",
                  $time, r.pixel_row, pixel_row);
         errors++;
      end
      if (dest_index !== r.dest_index) begin
         $display("%0t: dest_index mismatch: expected %0d, actual %0d",
                  $time, r.dest_index, dest_index);
         errors++;
      end
      if (last_row !== r.last_row) begin
         $display("%0t: last_row mismatch: expected %b, actual %b",
                  $time, r.last_row, last_row);
         errors++;
      end
   endfunction

   function int pending();
      return owed_rows.size();
   endfunction

endclass

module testbench;
   import ptra_pkg::*;

   // index 3 decodes to no register; writes there must be ignored
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam int RANDOM_ROWS   = 1750;
   localparam int IDLE_PCT      = 24;
   localparam int HOLD_CYCLES   = 80;      // long rsp hold-off, fills the pipe
   localparam int SETTLE_CYCLES = 4;       // quiet time after the last owed row
   localparam int CYCLE_LIMIT   = 200000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [5:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] low_plane, [15:8] high_plane
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [15:0] pixel_row, [28:16] dest_index, [31:29] zero
   logic        rsp_tlast;   // last_row

   tile_row_scoreboard sb;

   // steady: no idle cycles on either side while set
   bit steady;
   // rsp_hold_req: asks the receiver for one long hold-off
   bit rsp_hold_req;
   int cycles;

   planar_tile_row_arranger uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run as failed once CYCLE_LIMIT is reached.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Monitor: everything is sampled at the rising edge, before the block's
   // registers update. Results are checked before the same-edge input is
   // noted; a new row cannot come out in the edge it goes in.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_row(rsp_tdata[15:0], rsp_tdata[28:16], rsp_tlast);
         end
         if (csr_we) begin
            sb.write_csr(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            sb.note_row(req_tdata[7:0], req_tdata[15:8]);
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off counted here.
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_tready   <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Entered and left at a falling edge. tvalid stays high between
   // back-to-back rows; it only drops for an idle cycle.
   task automatic send_row(input logic [7:0] low_plane, input logic [7:0] high_plane);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {high_plane, low_plane};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // One register write, with a quiet cycle after so csr_we never toggles
   // twice in one step.
   task automatic write_reg(input logic [1:0] index, input logic [5:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Stop sending, wait for every owed row, then let the pipe go quiet so a
   // register write cannot land on a row in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly small images so wraps are frequent; some zero, max and oversize.
   function automatic logic [5:0] pick_size();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 60) return 6'($urandom_range(1, 4));
      if (p < 75) return 6'($urandom_range(5, 31));
      if (p < 85) return 6'd32;
      if (p < 90) return 6'd0;
      return 6'($urandom_range(33, 63));
   endfunction

   function automatic logic [7:0] pick_plane();
      // a few all-zero / all-one bytes among the random ones
      if ($urandom_range(0, 7) == 0) return {8{$urandom_range(0, 1) == 1}};
      return 8'($urandom);
   endfunction

   logic [15:0] directed_rows [8] = '{
      16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
      16'hAA55, 16'h55AA, 16'h8001, 16'h0180
   };

   initial begin
      int sent;
      int phase;
      int rows_this_phase;

      sb           = new();
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      steady       = 1'b0;
      rsp_hold_req = 1'b0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one tile at the reset geometry (1x1, last on the eighth row)
      for (int i = 0; i < 8; i++) send_row(directed_rows[i][7:0], directed_rows[i][15:8]);
      settle();

      // zero width acts as one, transposed from a wide value, spare index ignored
      write_reg(CSR_WIDTH_TILES, 6'd0);
      write_reg(CSR_HEIGHT_TILES, 6'd2);
      write_reg(CSR_TRANSPOSED, 6'h3F);
      write_reg(CSR_SPARE, 6'h3F);
      for (int i = 0; i < 8; i++) send_row(directed_rows[i][7:0], directed_rows[i][15:8]);
      settle();

      // oversize width clamps to 32, zero height, row-major, mid-image change
      write_reg(CSR_WIDTH_TILES, 6'd63);
      write_reg(CSR_HEIGHT_TILES, 6'd0);
      write_reg(CSR_TRANSPOSED, 6'h00);
      for (int i = 0; i < 8; i++) send_row(directed_rows[i][7:0], directed_rows[i][15:8]);
      settle();

      // Random phases: new geometry between phases, counters carry over, so
      // counters often sit beyond a freshly shrunk limit.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ROWS) begin
         if (phase == 1) begin
            // largest image, column-major
            write_reg(CSR_WIDTH_TILES, 6'd32);
            write_reg(CSR_HEIGHT_TILES, 6'd32);
            write_reg(CSR_TRANSPOSED, 6'd1);
         end else begin
            if ($urandom_range(0, 99) < 70) write_reg(CSR_WIDTH_TILES, pick_size());
            if ($urandom_range(0, 99) < 70) write_reg(CSR_HEIGHT_TILES, pick_size());
            if ($urandom_range(0, 99) < 50) write_reg(CSR_TRANSPOSED, 6'($urandom));
            if ($urandom_range(0, 99) < 10) write_reg(CSR_SPARE, 6'($urandom));
         end

         rows_this_phase = $urandom_range(8, 100);
         if (phase == 2) begin
            // receiver holds off while the sender keeps offering rows
            rsp_hold_req    = 1'b1;
            rows_this_phase = 150;
         end
         if (phase == 5) begin
            steady          = 1'b1;
            rows_this_phase = 200;
         end

         for (int i = 0; i < rows_this_phase; i++) send_row(pick_plane(), pick_plane());
         sent += rows_this_phase;
         steady = 1'b0;
         // the sender pauses here until every owed row has come back
         settle();
         phase++;
      end

      repeat (8) @(negedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d arranged rows never came out", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/ptra_pkg.sv
rtl/ptra_tile_counter.sv
rtl/ptra_row_pack.sv
rtl/planar_tile_row_arranger.sv
sim/testbench.sv
